### hdl/dffp_pkg.sv
// shared types and constants for the dual fixed frame byte parser
// no dependencies; used by every module under hdl

package dffp_pkg;

  // frame markers
  localparam logic [7:0] DISP_HEADER   = 8'h7D;
  localparam logic [7:0] DISP_TRAILER  = 8'h7C;
  localparam logic [7:0] SHAPE_HEADER  = 8'h7B;
  localparam logic [7:0] SHAPE_TRAILER = 8'h7A;

  // frame lengths in bytes and byte counter widths
  localparam int DISP_LEN    = 8;
  localparam int SHAPE_LEN   = 14;
  localparam int DISP_CNT_W  = $clog2(DISP_LEN);
  localparam int SHAPE_CNT_W = $clog2(SHAPE_LEN);

  // heading value for one full turn
  localparam logic [15:0] FULL_TURN = 16'd360;

  // node id of the leader
  localparam logic [1:0] LEADER_ID = 2'd0;

  // frame kind codes
  typedef enum logic {
    KIND_DISP  = 1'b0,
    KIND_SHAPE = 1'b1
  } frame_kind_e;

  // one result item
  typedef struct packed {
    frame_kind_e        kind;
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
    logic signed [15:0] value_c;
    logic signed [15:0] value_d;
    logic signed [15:0] value_e;
    logic signed [15:0] value_f;
    logic               heading_valid;
  } result_t;

  // handshake between the stages
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

### hdl/dffp_in_stage.sv
// input register for received bytes with valid/stall handshake
// depends on dffp_pkg

module dffp_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               advance_i,
  output dffp_pkg::stage_ctl_t ctl_o,
  output logic [7:0]         byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  // hold the byte while the parse stage cannot move
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  // valid tracking
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // byte register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  assign ctl_o.valid   = valid_q;
  assign ctl_o.advance = valid_q && advance_i;
  assign byte_o        = byte_q;

endmodule

### hdl/dffp_parser.sv
// both frame parsers: byte counters, frame buffers and result assembly
// depends on dffp_pkg

module dffp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic [1:0]        node_id_i,
  output logic              res_valid_o,
  output dffp_pkg::result_t res_o
);

  localparam int DW = dffp_pkg::DISP_CNT_W;
  localparam int SW = dffp_pkg::SHAPE_CNT_W;

  logic [DW-1:0] disp_cnt_q, disp_cnt_d, disp_cnt_mid;
  logic [SW-1:0] shape_cnt_q, shape_cnt_d, shape_cnt_eff;
  logic [7:0]    disp_buf_q  [dffp_pkg::DISP_LEN];
  logic [7:0]    shape_buf_q [dffp_pkg::SHAPE_LEN];

  logic disp_take, disp_last, disp_hit;
  logic shape_take, shape_last, shape_hit;
  logic [15:0] head_raw, head_swap;

  // displacement parser runs first
  assign disp_take = (disp_cnt_q != '0) || (byte_i == dffp_pkg::DISP_HEADER);
  assign disp_last = disp_take && (disp_cnt_q == DW'(dffp_pkg::DISP_LEN - 1));
  assign disp_hit  = disp_last && (byte_i == dffp_pkg::DISP_TRAILER);

  always_comb begin
    disp_cnt_mid = disp_cnt_q;
    if (disp_take) begin
      disp_cnt_mid = disp_last ? '0 : disp_cnt_q + DW'(1);
    end
  end

  // a good displacement frame restarts the shape parser on the same byte
  assign shape_cnt_eff = disp_hit ? '0 : shape_cnt_q;
  assign shape_take = (shape_cnt_eff != '0) || (byte_i == dffp_pkg::SHAPE_HEADER);
  assign shape_last = shape_take && (shape_cnt_eff == SW'(dffp_pkg::SHAPE_LEN - 1));
  assign shape_hit  = shape_last && (byte_i == dffp_pkg::SHAPE_TRAILER);

  // next counts; a good shape frame restarts the displacement parser
  always_comb begin
    shape_cnt_d = shape_cnt_eff;
    if (shape_take) begin
      shape_cnt_d = shape_last ? '0 : shape_cnt_eff + SW'(1);
    end
    disp_cnt_d = shape_hit ? '0 : disp_cnt_mid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_cnt_q  <= '0;
      shape_cnt_q <= '0;
    end else if (fire_i) begin
      disp_cnt_q  <= disp_cnt_d;
      shape_cnt_q <= shape_cnt_d;
    end
  end

  // frame buffers, written at the current byte position
  always_ff @(posedge clk_i) begin
    if (fire_i && disp_take) begin
      disp_buf_q[disp_cnt_q] <= byte_i;
    end
    if (fire_i && shape_take) begin
      shape_buf_q[shape_cnt_eff] <= byte_i;
    end
  end

  // leader heading with 0 and a full turn swapped
  assign head_raw = {disp_buf_q[5], disp_buf_q[6]};
  always_comb begin
    head_swap = head_raw;
    if (head_raw == 16'd0) begin
      head_swap = dffp_pkg::FULL_TURN;
    end else if (head_raw == dffp_pkg::FULL_TURN) begin
      head_swap = 16'd0;
    end
  end

  // result assembly; both frames cannot finish on the same byte
  always_comb begin
    res_o = '0;
    if (disp_hit) begin
      res_o.kind    = dffp_pkg::KIND_DISP;
      res_o.value_a = {disp_buf_q[1], disp_buf_q[2]};
      res_o.value_b = {disp_buf_q[3], disp_buf_q[4]};
      if (node_id_i == dffp_pkg::LEADER_ID) begin
        res_o.value_c       = head_swap;
        res_o.heading_valid = 1'b1;
      end
    end else begin
      res_o.kind    = dffp_pkg::KIND_SHAPE;
      res_o.value_a = {shape_buf_q[1],  shape_buf_q[2]};
      res_o.value_b = {shape_buf_q[3],  shape_buf_q[4]};
      res_o.value_c = {shape_buf_q[5],  shape_buf_q[6]};
      res_o.value_d = {shape_buf_q[7],  shape_buf_q[8]};
      res_o.value_e = {shape_buf_q[9],  shape_buf_q[10]};
      res_o.value_f = {shape_buf_q[11], shape_buf_q[12]};
    end
  end

  assign res_valid_o = fire_i && (disp_hit || shape_hit);

endmodule

### hdl/dffp_out_stage.sv
// result register with valid/stall handshake toward the consumer
// depends on dffp_pkg

module dffp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              res_valid_i,
  input  dffp_pkg::result_t res_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dffp_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  dffp_pkg::result_t res_q;

  // the parse stage may move when the register is empty or being drained
  assign advance_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = fire_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance_o && fire_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### hdl/dual_fixed_frame_byte_parser.sv
// top level of the dual fixed frame byte parser
// depends on dffp_pkg, dffp_in_stage, dffp_parser, dffp_out_stage
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------
//   in       | in_valid_i / in_stall_o    | rx_byte_i
//   out      | out_valid_o / out_stall_i  | frame_kind_o, value_a_o..f_o,
//            |                            | heading_valid_o
//   cfg      | cfg_valid_i / cfg_ready_o  | cfg_data_i (node id)
//
// one byte per cycle sustained while out_stall_i is low; a byte is parsed while it sits in
// the input register, and a completed frame is written to the result register as its
// last byte leaves the input register
// reset clears both byte counters, the node id and all valid flags
// a held result stalls the parse stage, which then stalls the input

module dual_fixed_frame_byte_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               frame_kind_o,
  output logic signed [15:0] value_a_o,
  output logic signed [15:0] value_b_o,
  output logic signed [15:0] value_c_o,
  output logic signed [15:0] value_d_o,
  output logic signed [15:0] value_e_o,
  output logic signed [15:0] value_f_o,
  output logic               heading_valid_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i
);

  logic                 advance;
  dffp_pkg::stage_ctl_t in_ctl;
  logic [7:0]           byte_q;
  logic                 res_valid;
  dffp_pkg::result_t    res, res_out;
  logic [1:0]           node_id_q;

  // node id register, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= 2'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      node_id_q <= cfg_data_i;
    end
  end

  // input register
  dffp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .ctl_o      (in_ctl),
    .byte_o     (byte_q)
  );

  // parsers
  dffp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_ctl.advance),
    .byte_i      (byte_q),
    .node_id_i   (node_id_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  dffp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_ctl.advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  // result fields
  assign frame_kind_o    = res_out.kind;
  assign value_a_o       = res_out.value_a;
  assign value_b_o       = res_out.value_b;
  assign value_c_o       = res_out.value_c;
  assign value_d_o       = res_out.value_d;
  assign value_e_o       = res_out.value_e;
  assign value_f_o       = res_out.value_f;
  assign heading_valid_o = res_out.heading_valid;

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_ctl.valid && out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // an accepted byte is in the input register next cycle
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_ctl.valid)
    else $error("accepted byte not captured");

  // shape results never carry heading
  a_shape_heading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_kind_o) |-> !heading_valid_o)
    else $error("shape result with heading flag");

  // displacement results leave the shape-only fields at zero
  a_disp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_kind_o) |->
      (value_d_o == 16'sd0 && value_e_o == 16'sd0 && value_f_o == 16'sd0))
    else $error("displacement result with nonzero shape fields");

endmodule

### test/dual_fixed_frame_byte_parser_test.sv
// self-checking testbench for the dual fixed frame byte parser: a byte-level predictor or a typed-in
// result checks every result; directed frames come first, then random frames, noise and cut-off frames
// depends on dffp_pkg and dual_fixed_frame_byte_parser

module dual_fixed_frame_byte_parser_test;

  localparam int PIPE_LATENCY  = 1;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_BYTES   = 130;
  localparam int NUM_PHASES    = 6;
  localparam int NUM_DIR_ROWS  = 5;

  typedef enum logic [1:0] {
    ROW_NOISE,
    ROW_DISP,
    ROW_SHAPE
  } row_kind_e;

  // one directed row: a single byte or a whole frame, with an optional typed-in result
  typedef struct packed {
    row_kind_e         kind;
    logic [0:5][15:0]  vals;
    logic              trailer_ok;
    logic              typed;
    dffp_pkg::result_t want;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               frame_kind_o;
  logic signed [15:0] value_a_o;
  logic signed [15:0] value_b_o;
  logic signed [15:0] value_c_o;
  logic signed [15:0] value_d_o;
  logic signed [15:0] value_e_o;
  logic signed [15:0] value_f_o;
  logic               heading_valid_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_data_i;

  // parser model state
  logic [1:0]  pred_node_id;
  logic [7:0]  disp_bytes [dffp_pkg::DISP_LEN];
  int          disp_fill;
  logic [7:0]  shape_bytes [dffp_pkg::SHAPE_LEN];
  int          shape_fill;

  dffp_pkg::result_t frames_due [$];
  int                mismatches;
  int unsigned       cycle_count;
  int                bytes_sent;
  logic              idle_on;
  dir_row_t          dir_rows [NUM_DIR_ROWS];

  dual_fixed_frame_byte_parser DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_kind_o    (frame_kind_o),
    .value_a_o       (value_a_o),
    .value_b_o       (value_b_o),
    .value_c_o       (value_c_o),
    .value_d_o       (value_d_o),
    .value_e_o       (value_e_o),
    .value_f_o       (value_f_o),
    .heading_valid_o (heading_valid_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic dffp_pkg::result_t make_result(input dffp_pkg::frame_kind_e k,
                                                    input logic [15:0] a,
                                                    input logic [15:0] b,
                                                    input logic [15:0] c,
                                                    input logic [15:0] d,
                                                    input logic [15:0] e,
                                                    input logic [15:0] f,
                                                    input logic hv);
    dffp_pkg::result_t r;
    r.kind          = k;
    r.value_a       = a;
    r.value_b       = b;
    r.value_c       = c;
    r.value_d       = d;
    r.value_e       = e;
    r.value_f       = f;
    r.heading_valid = hv;
    return r;
  endfunction

  // feed one byte to both frame parsers, displacement first
  task automatic parse_byte(input logic [7:0] b, output logic got,
                            output dffp_pkg::result_t r);
    logic [15:0] head;
    got  = 1'b0;
    r    = '0;
    head = '0;
    // displacement parser
    if (disp_fill != 0 || b == dffp_pkg::DISP_HEADER) begin
      disp_bytes[disp_fill] = b;
      disp_fill++;
      if (disp_fill == dffp_pkg::DISP_LEN) begin
        disp_fill = 0;
        if (disp_bytes[dffp_pkg::DISP_LEN-1] == dffp_pkg::DISP_TRAILER) begin
          r.kind    = dffp_pkg::KIND_DISP;
          r.value_a = {disp_bytes[1], disp_bytes[2]};
          r.value_b = {disp_bytes[3], disp_bytes[4]};
          // leader reports heading, with 0 and a full turn swapped
          if (pred_node_id == dffp_pkg::LEADER_ID) begin
            head = {disp_bytes[5], disp_bytes[6]};
            if (head == 16'd0) head = dffp_pkg::FULL_TURN;
            else if (head == dffp_pkg::FULL_TURN) head = 16'd0;
            r.value_c       = head;
            r.heading_valid = 1'b1;
          end
          shape_fill = 0;
          got        = 1'b1;
        end
      end
    end
    // shape parser sees the same byte afterwards
    if (shape_fill != 0 || b == dffp_pkg::SHAPE_HEADER) begin
      shape_bytes[shape_fill] = b;
      shape_fill++;
      if (shape_fill == dffp_pkg::SHAPE_LEN) begin
        shape_fill = 0;
        if (shape_bytes[dffp_pkg::SHAPE_LEN-1] == dffp_pkg::SHAPE_TRAILER && !got) begin
          r.kind          = dffp_pkg::KIND_SHAPE;
          r.value_a       = {shape_bytes[1], shape_bytes[2]};
          r.value_b       = {shape_bytes[3], shape_bytes[4]};
          r.value_c       = {shape_bytes[5], shape_bytes[6]};
          r.value_d       = {shape_bytes[7], shape_bytes[8]};
          r.value_e       = {shape_bytes[9], shape_bytes[10]};
          r.value_f       = {shape_bytes[11], shape_bytes[12]};
          r.heading_valid = 1'b0;
          disp_fill       = 0;
          got             = 1'b1;
        end
      end
    end
  endtask

  // one byte transfer, with an optional idle burst in front
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input dffp_pkg::result_t want);
    logic              stalled;
    logic              got;
    dffp_pkg::result_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    forever begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
      if (!stalled) break;
    end
    parse_byte(b, got, r);
    if (typed) frames_due.push_back(want);
    else if (got) frames_due.push_back(r);
    bytes_sent++;
  endtask

  // header, big-endian words, trailer; a typed result goes with the trailer byte
  task automatic send_frame(input row_kind_e k, input logic [0:5][15:0] vals,
                            input logic [7:0] trailer, input logic typed,
                            input dffp_pkg::result_t want);
    int words;
    int i;
    words = (k == ROW_DISP) ? 3 : 6;
    send_byte((k == ROW_DISP) ? dffp_pkg::DISP_HEADER : dffp_pkg::SHAPE_HEADER, 1'b0, want);
    for (i = 0; i < words; i++) begin
      send_byte(vals[i][15:8], 1'b0, want);
      send_byte(vals[i][7:0], 1'b0, want);
    end
    send_byte(trailer, typed, want);
  endtask

  // extremes and embedded frame markers show up often
  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return {8'h7A + 8'($urandom_range(0, 3)), 8'($urandom)};
      5:       return {8'($urandom), 8'h7A + 8'($urandom_range(0, 3))};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_frame(input row_kind_e k, input logic good);
    logic [0:5][15:0]  vals;
    logic [7:0]        trailer;
    logic [7:0]        good_trailer;
    dffp_pkg::result_t none;
    int                i;
    none = '0;
    for (i = 0; i < 6; i++) vals[i] = rand_word();
    // heading around the swap points
    if (k == ROW_DISP) begin
      case ($urandom_range(0, 5))
        0: vals[2] = 16'd0;
        1: vals[2] = dffp_pkg::FULL_TURN;
        2: vals[2] = dffp_pkg::FULL_TURN - 16'd1;
        3: vals[2] = dffp_pkg::FULL_TURN + 16'd1;
        default: ;
      endcase
    end
    good_trailer = (k == ROW_DISP) ? dffp_pkg::DISP_TRAILER : dffp_pkg::SHAPE_TRAILER;
    trailer      = good_trailer;
    if (!good) begin
      do trailer = 8'($urandom); while (trailer == good_trailer);
    end
    send_frame(k, vals, trailer, 1'b0, none);
  endtask

  // node id write, only once every expected frame is out and the pipe has drained
  task automatic write_node_id(input logic [1:0] id);
    logic rdy;
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= id;
    forever begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
      if (rdy) break;
    end
    cfg_valid_i  <= 1'b0;
    pred_node_id = id;
  endtask

  // result side stall bursts
  initial begin : stall_driver
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // compare each result transfer against the oldest expected frame
  always @(negedge clk_i) begin : result_monitor
    dffp_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("unexpected frame, kind %0d a %0d", frame_kind_o,
                                  value_a_o));
      end else begin
        want = frames_due.pop_front();
        if (frame_kind_o != want.kind)
          report_mismatch($sformatf("frame_kind got %0d want %0d", frame_kind_o, want.kind));
        if (value_a_o != want.value_a)
          report_mismatch($sformatf("value_a got %0d want %0d", value_a_o, want.value_a));
        if (value_b_o != want.value_b)
          report_mismatch($sformatf("value_b got %0d want %0d", value_b_o, want.value_b));
        if (value_c_o != want.value_c)
          report_mismatch($sformatf("value_c got %0d want %0d", value_c_o, want.value_c));
        if (value_d_o != want.value_d)
          report_mismatch($sformatf("value_d got %0d want %0d", value_d_o, want.value_d));
        if (value_e_o != want.value_e)
          report_mismatch($sformatf("value_e got %0d want %0d", value_e_o, want.value_e));
        if (value_f_o != want.value_f)
          report_mismatch($sformatf("value_f got %0d want %0d", value_f_o, want.value_f));
        if (heading_valid_o != want.heading_valid)
          report_mismatch($sformatf("heading_valid got %0d want %0d", heading_valid_o,
                                    want.heading_valid));
      end
    end
  end

  initial begin : stimulus
    logic [1:0]        phase_ids [NUM_PHASES];
    dffp_pkg::result_t none;
    int                r;
    int                p;
    int                quota;
    int                sel;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    rx_byte_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    idle_on      = 1'b1;
    mismatches   = 0;
    bytes_sent   = 0;
    none         = '0;
    pred_node_id = dffp_pkg::LEADER_ID;
    disp_fill    = 0;
    shape_fill   = 0;
    foreach (disp_bytes[i]) disp_bytes[i] = '0;
    foreach (shape_bytes[i]) shape_bytes[i] = '0;
    phase_ids = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd0};

    // directed rows, node id at its reset value (leader)
    // stray byte at position zero is dropped
    dir_rows[0] = '{ROW_NOISE, {16'h00FF, 80'h0}, 1'b1, 1'b0, none};
    // extremes, heading 0 reads as a full turn
    dir_rows[1] = '{ROW_DISP, {16'h7FFF, 16'h8000, 16'h0000, 48'h0}, 1'b1, 1'b1,
                    make_result(dffp_pkg::KIND_DISP, 16'h7FFF, 16'h8000, 16'd360, 16'h0,
                                16'h0, 16'h0, 1'b1)};
    // shape header inside dx gets cleared by the good frame; heading 360 reads as 0
    dir_rows[2] = '{ROW_DISP, {16'h7B00, 16'hFFFF, 16'd360, 48'h0}, 1'b1, 1'b1,
                    make_result(dffp_pkg::KIND_DISP, 16'h7B00, 16'hFFFF, 16'd0, 16'h0,
                                16'h0, 16'h0, 1'b1)};
    // bad trailer, no frame
    dir_rows[3] = '{ROW_DISP, {16'h0001, 16'h0000, 16'd359, 48'h0}, 1'b0, 1'b0, none};
    // displacement header inside a good shape frame gets cleared
    dir_rows[4] = '{ROW_SHAPE, {16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h7D7C, 16'h0001},
                    1'b1, 1'b1,
                    make_result(dffp_pkg::KIND_SHAPE, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                16'h7D7C, 16'h0001, 1'b0)};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < NUM_DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_NOISE) begin
        send_byte(dir_rows[r].vals[0][7:0], 1'b0, none);
      end else begin
        send_frame(dir_rows[r].kind, dir_rows[r].vals,
                   dir_rows[r].trailer_ok ?
                     ((dir_rows[r].kind == ROW_DISP) ?
                        dffp_pkg::DISP_TRAILER : dffp_pkg::SHAPE_TRAILER) :
                     ((dir_rows[r].kind == ROW_DISP) ?
                        dffp_pkg::DISP_TRAILER : dffp_pkg::SHAPE_TRAILER) ^ 8'h80,
                   dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // random phases, one node id each; the last one runs without idling
    for (p = 0; p < NUM_PHASES; p++) begin
      write_node_id(phase_ids[p]);
      idle_on = (p != NUM_PHASES - 1);
      quota   = bytes_sent + PHASE_BYTES;
      while (bytes_sent < quota) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          send_random_frame(ROW_DISP, 1'b1);
        end else if (sel < 80) begin
          send_random_frame(ROW_SHAPE, 1'b1);
        end else if (sel < 88) begin
          send_random_frame($urandom_range(0, 1) ? ROW_DISP : ROW_SHAPE, 1'b0);
        end else if (sel < 95) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, none);
        end else begin
          // frame cut short
          send_byte($urandom_range(0, 1) ? dffp_pkg::DISP_HEADER : dffp_pkg::SHAPE_HEADER,
                    1'b0, none);
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0, none);
        end
      end
    end

    // drain
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
